/* rtl/tdce_pkg.sv */
package tdce_pkg;

  localparam int ADDR_W = 16;
  localparam int TILE_W = 8;
  localparam int COUNT_W = 7;
  localparam int ROW_TILES = 32;
  localparam int ROW_BITS = $clog2(ROW_TILES);
  localparam int QUEUE_DEPTH = 4;
  localparam int PADDR_W = 3;

  localparam logic [TILE_W-1:0] CLEAR_TILE = 8'hEE;
  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(ROW_TILES);
  localparam logic [PADDR_W-1:0] REG_TRANSITION_MODE = 3'd0;

  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CMD  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic                end_mark;
    logic [ADDR_W-1:0]   addr;
    logic [TILE_W-1:0]   tile;
    logic [COUNT_W-1:0]  count;
    logic                column;
  } entry_t;

  function automatic logic [ADDR_W-1:0] next_address(input logic [ADDR_W-1:0] a,
                                                     input logic column);
    logic [ROW_BITS-1:0] low_part;
    low_part = a[ROW_BITS-1:0] + 1'b1;
    if (column) begin
      next_address = a + ROW_STEP;
    end else begin
      next_address = {a[ADDR_W-1:ROW_BITS], low_part};
    end
  endfunction

endpackage

/* rtl/tdce_front.sv */
module tdce_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [tdce_pkg::TILE_W-1:0]  list_byte,
  input  logic                         transition_mode,
  output logic                         push,
  output tdce_pkg::entry_t             push_entry
);

  tdce_pkg::phase_t phase, phase_next;
  logic [tdce_pkg::ADDR_W-1:0]  dest_pointer;
  logic [tdce_pkg::TILE_W-1:0]  dest_high_hold;
  logic [tdce_pkg::COUNT_W-1:0] remaining_count;
  logic                         mode_column;
  logic                         mode_fill;
  logic                         transparent;

  assign transparent = transition_mode && (list_byte == tdce_pkg::CLEAR_TILE);

  always_comb begin
    phase_next = phase;
    case (phase)
      tdce_pkg::PH_HIGH: begin
        if (accept && (list_byte != '0)) phase_next = tdce_pkg::PH_LOW;
      end
      tdce_pkg::PH_LOW: begin
        if (accept) phase_next = tdce_pkg::PH_CMD;
      end
      tdce_pkg::PH_CMD: begin
        if (accept) phase_next = tdce_pkg::PH_DATA;
      end
      tdce_pkg::PH_DATA: begin
        if (accept && (mode_fill || (remaining_count <= tdce_pkg::COUNT_W'(1)))) begin
          phase_next = tdce_pkg::PH_HIGH;
        end
      end
      default: phase_next = tdce_pkg::PH_HIGH;
    endcase
  end

  always_comb begin
    push = 1'b0;
    push_entry = '0;
    case (phase)
      tdce_pkg::PH_HIGH: begin
        push = accept && (list_byte == '0);
        push_entry.end_mark = 1'b1;
        push_entry.count = tdce_pkg::COUNT_W'(1);
      end
      tdce_pkg::PH_DATA: begin
        push = accept && (mode_fill || !transparent);
        push_entry.addr = dest_pointer;
        push_entry.tile = list_byte;
        push_entry.column = mode_column;
        push_entry.count = mode_fill ? remaining_count : tdce_pkg::COUNT_W'(1);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tdce_pkg::PH_HIGH;
      dest_pointer <= '0;
      dest_high_hold <= '0;
      remaining_count <= '0;
      mode_column <= 1'b0;
      mode_fill <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (phase)
          tdce_pkg::PH_HIGH: begin
            if (list_byte != '0) dest_high_hold <= list_byte;
          end
          tdce_pkg::PH_LOW: begin
            dest_pointer <= {dest_high_hold, list_byte};
          end
          tdce_pkg::PH_CMD: begin
            remaining_count <= {1'b0, list_byte[5:0]} + tdce_pkg::COUNT_W'(1);
            mode_column <= list_byte[7];
            mode_fill <= list_byte[6] && !transition_mode;
          end
          tdce_pkg::PH_DATA: begin
            if (mode_fill) begin
              remaining_count <= '0;
            end else begin
              dest_pointer <= tdce_pkg::next_address(dest_pointer, mode_column);
              if (remaining_count != '0) remaining_count <= remaining_count - 1'b1;
            end
          end
          default: begin
            dest_pointer <= dest_pointer;
          end
        endcase
      end
    end
  end

endmodule

/* rtl/tdce_queue.sv */
module tdce_queue #(
  parameter int DEPTH = tdce_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tdce_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output tdce_pkg::entry_t head,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tdce_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full = (fill == FULL_CNT);
  assign not_empty = (fill != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop && not_empty) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if ((push && !full) && !(pop && not_empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/tdce_back.sv */
module tdce_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tdce_pkg::entry_t              q_head,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          result_kind,
  output logic [tdce_pkg::ADDR_W-1:0]   write_address,
  output logic [tdce_pkg::TILE_W-1:0]   write_tile,
  output logic                          last_of_run
);

  logic [tdce_pkg::COUNT_W-1:0] rem;
  logic                         column;
  logic                         load;
  logic                         done;

  assign last_of_run = (rem == tdce_pkg::COUNT_W'(1));
  assign done = result_valid && result_ready;
  assign load = q_valid && (!result_valid || (result_ready && last_of_run));
  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (done && last_of_run) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= q_head.end_mark;
      write_address <= q_head.addr;
      write_tile <= q_head.tile;
      rem <= q_head.count;
      column <= q_head.column;
    end else if (done && !last_of_run) begin
      write_address <= tdce_pkg::next_address(write_address, column);
      rem <= rem - 1'b1;
    end
  end

endmodule

/* rtl/tilemap_draw_command_engine_unit.sv */
// an accepted byte's entry is queued, then loaded into the back end's result registers
// throughput: one list byte per cycle for header and copy bytes, one result per ready cycle
// a fill byte gives its run of 1 to 64 results at one per ready cycle from the back end,
// and the input stalls once the command queue between front and back is full
// reset: synchronous rst returns the parser to the destination high byte,
// empties the queue, drops any pending result and clears transition_mode
module tilemap_draw_command_engine_unit #(
  parameter int QUEUE_DEPTH = tdce_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdce_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            list_valid,
  output logic                            list_ready,
  input  logic [tdce_pkg::TILE_W-1:0]     list_byte,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            result_kind,
  output logic [tdce_pkg::ADDR_W-1:0]     write_address,
  output logic [tdce_pkg::TILE_W-1:0]     write_tile,
  output logic                            last_of_run
);

  logic             transition_mode;
  logic             accept;
  logic             push;
  tdce_pkg::entry_t push_entry;
  logic             q_full;
  logic             q_valid;
  tdce_pkg::entry_t q_head;
  logic             pop;

  assign pready = 1'b1;
  assign prdata = (paddr == tdce_pkg::REG_TRANSITION_MODE) ? {31'b0, transition_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == tdce_pkg::REG_TRANSITION_MODE)) begin
      transition_mode <= pwdata[0];
    end
  end

  assign list_ready = !q_full;
  assign accept = list_valid && list_ready;

  tdce_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .list_byte       (list_byte),
    .transition_mode (transition_mode),
    .push            (push),
    .push_entry      (push_entry)
  );

  tdce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (q_head),
    .not_empty  (q_valid)
  );

  tdce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result_kind   (result_kind),
    .write_address (write_address),
    .write_tile    (write_tile),
    .last_of_run   (last_of_run)
  );

endmodule

/* test/tilemap_draw_command_engine_unit_test.sv */
module tilemap_draw_command_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_CYCLES = 16;
  localparam int RANDOM_ITEMS = 96;
  localparam logic [tdce_pkg::PADDR_W-1:0] REG_UNUSED = 3'd4;

  typedef struct packed {
    logic                        kind;
    logic [tdce_pkg::ADDR_W-1:0] addr;
    logic [tdce_pkg::TILE_W-1:0] tile;
    logic                        last;
  } draw_write_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [tdce_pkg::TILE_W-1:0]  value;
    logic [tdce_pkg::PADDR_W-1:0] reg_addr;
    logic                         typed;
    draw_write_t                  want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tdce_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic list_valid = 1'b0;
  logic list_ready;
  logic [tdce_pkg::TILE_W-1:0] list_byte = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic result_kind;
  logic [tdce_pkg::ADDR_W-1:0] write_address;
  logic [tdce_pkg::TILE_W-1:0] write_tile;
  logic last_of_run;

  tilemap_draw_command_engine_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .list_valid(list_valid),
    .list_ready(list_ready),
    .list_byte(list_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_kind(result_kind),
    .write_address(write_address),
    .write_tile(write_tile),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the engine state
  tdce_pkg::phase_t            shadow_phase = tdce_pkg::PH_HIGH;
  logic [tdce_pkg::ADDR_W-1:0] shadow_ptr = '0;
  logic [tdce_pkg::TILE_W-1:0] shadow_hold = '0;
  int                          shadow_left = 0;
  logic                        shadow_column = 1'b0;
  logic                        shadow_fill = 1'b0;
  logic                        shadow_transition = 1'b0;

  draw_write_t expected_writes[$];
  stim_row_t   script[$];

  int errors = 0;
  int bytes_sent = 0;
  int writes_checked = 0;
  int ends_checked = 0;
  int cfg_writes = 0;
  int burst_left = 4;

  function automatic logic [tdce_pkg::ADDR_W-1:0] advance_pointer(
      input logic [tdce_pkg::ADDR_W-1:0] a, input logic column);
    logic [tdce_pkg::ROW_BITS-1:0] col_part;
    col_part = a[tdce_pkg::ROW_BITS-1:0] + 1'b1;
    if (column) return a + tdce_pkg::ADDR_W'(tdce_pkg::ROW_TILES);
    return {a[tdce_pkg::ADDR_W-1:tdce_pkg::ROW_BITS], col_part};
  endfunction

  task automatic push_write(input logic kind, input logic [tdce_pkg::ADDR_W-1:0] addr,
                            input logic [tdce_pkg::TILE_W-1:0] tile, input logic last);
    draw_write_t w;
    w.kind = kind;
    w.addr = addr;
    w.tile = tile;
    w.last = last;
    expected_writes.push_back(w);
  endtask

  task automatic predict_list_byte(input logic [tdce_pkg::TILE_W-1:0] b);
    int i;
    case (shadow_phase)
      tdce_pkg::PH_HIGH: begin
        if (b == '0) begin
          push_write(1'b1, '0, '0, 1'b1);
        end else begin
          shadow_hold = b;
          shadow_phase = tdce_pkg::PH_LOW;
        end
      end
      tdce_pkg::PH_LOW: begin
        shadow_ptr = {shadow_hold, b};
        shadow_phase = tdce_pkg::PH_CMD;
      end
      tdce_pkg::PH_CMD: begin
        shadow_left = int'(b[5:0]) + 1;
        shadow_column = b[7];
        shadow_fill = b[6] && !shadow_transition;
        shadow_phase = tdce_pkg::PH_DATA;
      end
      default: begin
        if (shadow_fill) begin
          for (i = 0; i < shadow_left; i++) begin
            push_write(1'b0, shadow_ptr, b, i == shadow_left - 1);
            shadow_ptr = advance_pointer(shadow_ptr, shadow_column);
          end
          shadow_left = 0;
          shadow_phase = tdce_pkg::PH_HIGH;
        end else begin
          if (!(shadow_transition && b == tdce_pkg::CLEAR_TILE)) begin
            push_write(1'b0, shadow_ptr, b, 1'b1);
          end
          shadow_ptr = advance_pointer(shadow_ptr, shadow_column);
          if (shadow_left > 0) shadow_left--;
          if (shadow_left == 0) shadow_phase = tdce_pkg::PH_HIGH;
        end
      end
    endcase
  endtask

  task automatic pause_sender(input int cycles);
    list_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic int next_burst();
    if ($urandom_range(0, 4) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 10);
  endfunction

  task automatic send_list_byte(input logic [tdce_pkg::TILE_W-1:0] b, input logic typed,
                                input draw_write_t want);
    list_valid <= 1'b1;
    list_byte <= b;
    do @(posedge clk); while (!list_ready);
    predict_list_byte(b);
    if (typed) expected_writes[expected_writes.size() - 1] = want;
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause_sender(($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5));
      burst_left = next_burst();
    end
  endtask

  // stop feeding, let every expected result drain, then give the back end time to empty
  task automatic settle_block();
    list_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    burst_left = next_burst();
  endtask

  task automatic write_register(input logic [tdce_pkg::PADDR_W-1:0] addr,
                                input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == tdce_pkg::REG_TRANSITION_MODE) shadow_transition = value[0];
    cfg_writes++;
  endtask

  function automatic stim_row_t byte_row(input logic [tdce_pkg::TILE_W-1:0] b);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BYTE;
    r.value = b;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [tdce_pkg::TILE_W-1:0] b,
                                          input logic kind,
                                          input logic [tdce_pkg::ADDR_W-1:0] addr,
                                          input logic [tdce_pkg::TILE_W-1:0] tile,
                                          input logic last);
    stim_row_t r;
    r = byte_row(b);
    r.typed = 1'b1;
    r.want.kind = kind;
    r.want.addr = addr;
    r.want.tile = tile;
    r.want.last = last;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [tdce_pkg::PADDR_W-1:0] addr,
                                        input logic value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_addr = addr;
    r.value = tdce_pkg::TILE_W'(value);
    return r;
  endfunction

  function automatic logic [tdce_pkg::TILE_W-1:0] pick_list_byte();
    int r;
    logic [5:0] run;
    r = $urandom_range(0, 99);
    if (r < 8) return tdce_pkg::TILE_W'($urandom);
    case (shadow_phase)
      tdce_pkg::PH_HIGH: begin
        if ($urandom_range(0, 11) == 0) return '0;
        return tdce_pkg::TILE_W'($urandom_range(1, 255));
      end
      tdce_pkg::PH_LOW: return tdce_pkg::TILE_W'($urandom);
      tdce_pkg::PH_CMD: begin
        r = $urandom_range(0, 19);
        if (r < 15) run = 6'($urandom_range(0, 5));
        else if (r < 18) run = 6'($urandom_range(0, 63));
        else run = 6'h3F;
        return {2'($urandom), run};
      end
      default: begin
        if ($urandom_range(0, 3) == 0) return tdce_pkg::CLEAR_TILE;
        return tdce_pkg::TILE_W'($urandom);
      end
    endcase
  endfunction

  task automatic report_field(input string name, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // receiver: stalls on a changing pattern and checks each accepted result
  rx_style_t rx_style = RX_OPEN;
  int rx_left = 30;

  always @(posedge clk) begin : result_check
    draw_write_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual kind %0h addr %0h tile %0h last %0h",
                 $time, result_kind, write_address, write_tile, last_of_run);
      end else begin
        want = expected_writes.pop_front();
        if (result_kind !== want.kind) report_field("result_kind", want.kind, result_kind);
        if (write_address !== want.addr) report_field("write_address", want.addr, write_address);
        if (write_tile !== want.tile) report_field("write_tile", want.tile, write_tile);
        if (last_of_run !== want.last) report_field("last_of_run", want.last, last_of_run);
        if (want.kind) ends_checked++;
        else writes_checked++;
      end
    end
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 80);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_OPEN: result_ready <= 1'b1;
      RX_COIN: result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default: result_ready <= !result_ready;
    endcase
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int i;
    int until_cfg;
    stim_row_t row;
    logic [tdce_pkg::TILE_W-1:0] b;

    script.push_back(cfg_row(tdce_pkg::REG_TRANSITION_MODE, 1'b0));
    script.push_back(typed_row(8'h00, 1'b1, 16'h0000, 8'h00, 1'b1));
    // highest destination, shortest row copy
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'h00));
    script.push_back(typed_row(8'hFF, 1'b0, 16'hFFFF, 8'hFF, 1'b1));
    // row fill wrapping inside its row
    script.push_back(byte_row(8'h12));
    script.push_back(byte_row(8'h3E));
    script.push_back(byte_row(8'h43));
    script.push_back(byte_row(8'h55));
    // longest column fill, wrapping at 16 bits
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'hE0));
    script.push_back(byte_row(8'hFF));
    script.push_back(byte_row(8'h00));
    // fill decided at the command byte, then transition mode switched on
    script.push_back(byte_row(8'h40));
    script.push_back(byte_row(8'h00));
    script.push_back(byte_row(8'h41));
    script.push_back(cfg_row(tdce_pkg::REG_TRANSITION_MODE, 1'b1));
    script.push_back(byte_row(tdce_pkg::CLEAR_TILE));
    // fill bit ignored, transparent tile skipped, then mode cleared mid run
    script.push_back(byte_row(8'h20));
    script.push_back(byte_row(8'h1F));
    script.push_back(byte_row(8'h42));
    script.push_back(byte_row(tdce_pkg::CLEAR_TILE));
    script.push_back(byte_row(8'h01));
    script.push_back(cfg_row(tdce_pkg::REG_TRANSITION_MODE, 1'b0));
    script.push_back(cfg_row(REG_UNUSED, 1'b1));
    script.push_back(byte_row(tdce_pkg::CLEAR_TILE));
    script.push_back(typed_row(8'h00, 1'b1, 16'h0000, 8'h00, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_CFG) begin
        settle_block();
        write_register(row.reg_addr, 32'(row.value));
      end else begin
        send_list_byte(row.value, row.typed, row.want);
      end
    end

    until_cfg = $urandom_range(20, 35);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (until_cfg == 0) begin
        settle_block();
        if ($urandom_range(0, 6) == 0) begin
          write_register(REG_UNUSED, 32'($urandom_range(0, 1)));
        end else begin
          write_register(tdce_pkg::REG_TRANSITION_MODE, 32'(!shadow_transition));
        end
        until_cfg = $urandom_range(20, 35);
      end else if ($urandom_range(0, 49) == 0) begin
        settle_block();
      end
      until_cfg--;
      b = pick_list_byte();
      send_list_byte(b, 1'b0, '0);
    end

    settle_block();
    $display("%0d list bytes sent over %0d register writes", bytes_sent, cfg_writes);
    $display("%0d tile writes and %0d end marks checked", writes_checked, ends_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
